// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

  // Queue geometry.
  localparam int unsigned DEPTH        = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned COUNT_W      = $clog2(DEPTH + 1);

  // Port field widths.
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned WORD_W  = 32;

  // Request codes.
  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request beat
    logic execute;  // perform the latched request
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ctrl.sv =====
// Sequencing controller of the sorted priority queue.
`default_nettype none

module spq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  output spq_pkg::dp_cmd_t     cmd_o,
  output logic                 done_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next-state logic: take a beat, execute it, then present the result.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC:  state_d = S_RESP;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Command and handshake outputs.
  assign busy          = (state_q != S_IDLE);
  assign cmd_o.capture = (state_q == S_IDLE) && start;
  assign cmd_o.execute = (state_q == S_EXEC);
  assign done_o        = (state_q == S_RESP);

endmodule

`default_nettype wire

// ===== hw/rtl/spq_datapath.sv =====
// Slot array, insert and remove logic, and result registers of the queue.
`default_nettype none

module spq_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire spq_pkg::dp_cmd_t                  cmd_i,
  input  wire logic                              req_type_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]        entry_priority_i,
  input  wire logic [spq_pkg::WORD_W-1:0]        entry_payload_i,
  output logic [spq_pkg::STAT_W-1:0]             status_o,
  output logic [spq_pkg::PRIO_W-1:0]             head_priority_o,
  output logic [spq_pkg::WORD_W-1:0]             head_payload_o,
  output logic [spq_pkg::FILL_W-1:0]             fill_level_o,
  output logic                                   is_empty_o,
  output logic                                   is_full_o
);
  import spq_pkg::*;

  // Latched request beat.
  logic                    req_q;
  logic [PRIO_W-1:0]       pri_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // Slots and fill count.
  logic [PRIO_W-1:0]       slot_pri_q [DEPTH];
  logic [PAYLOAD_BITS-1:0] slot_pay_q [DEPTH];
  logic [PRIO_W-1:0]       slot_pri_d [DEPTH];
  logic [PAYLOAD_BITS-1:0] slot_pay_d [DEPTH];
  logic [COUNT_W-1:0]      count_q, count_d;

  // Result registers.
  logic [STAT_W-1:0]       status_q, status_d;
  logic [PRIO_W-1:0]       hpri_q, hpri_d;
  logic [WORD_W-1:0]       hpay_q, hpay_d;

  logic [DEPTH-1:0]        shift_mask;
  logic                    q_empty, q_full;

  assign q_empty = (count_q == '0);
  assign q_full  = (count_q >= COUNT_W'(DEPTH));

  // A slot moves back when the new entry goes at or ahead of it. The stored
  // levels are sorted, so the compares form a contiguous run to the tail.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift_mask[i] = (COUNT_W'(i) >= count_q) || (pri_q <= slot_pri_q[i]);
    end
  end

  // Next slot contents, count and result for the latched request.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_pri_d[i] = slot_pri_q[i];
      slot_pay_d[i] = slot_pay_q[i];
    end
    count_d  = count_q;
    status_d = STAT_OK;
    hpri_d   = '0;
    hpay_d   = '0;
    if (req_q == REQ_ENQ) begin
      if (q_full) begin
        status_d = STAT_FULL;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (shift_mask[i]) begin
            if (i == 0) begin
              slot_pri_d[i] = pri_q;
              slot_pay_d[i] = pay_q;
            end else if (!shift_mask[i-1]) begin
              slot_pri_d[i] = pri_q;
              slot_pay_d[i] = pay_q;
            end else begin
              slot_pri_d[i] = slot_pri_q[i-1];
              slot_pay_d[i] = slot_pay_q[i-1];
            end
          end
        end
        count_d = count_q + 1'b1;
      end
    end else begin
      if (q_empty) begin
        status_d = STAT_EMPTY;
      end else begin
        hpri_d = slot_pri_q[0];
        hpay_d = WORD_W'(slot_pay_q[0]);
        for (int i = 0; i < DEPTH - 1; i++) begin
          slot_pri_d[i] = slot_pri_q[i+1];
          slot_pay_d[i] = slot_pay_q[i+1];
        end
        count_d = count_q - 1'b1;
      end
    end
  end

  // Control state: the fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  // Payload registers: request latch, slots and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      pri_q <= entry_priority_i;
      pay_q <= PAYLOAD_BITS'(entry_payload_i);
    end
    if (cmd_i.execute) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_pri_q[i] <= slot_pri_d[i];
        slot_pay_q[i] <= slot_pay_d[i];
      end
      status_q <= status_d;
      hpri_q   <= hpri_d;
      hpay_q   <= hpay_d;
    end
  end

  // Result outputs; the count registers already reflect the request.
  assign status_o        = status_q;
  assign head_priority_o = hpri_q;
  assign head_payload_o  = hpay_q;
  assign fill_level_o    = FILL_W'(count_q);
  assign is_empty_o      = q_empty;
  assign is_full_o       = q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue: a request is taken with start while busy is low; its
// result is registered in the execute state and shown for one cycle in the
// response state, marked by done_o. The receiver cannot stall the result,
// so it must take every done_o beat. Each request passes through latch,
// execute and present, and the next one can be taken in the cycle after
// done_o. The insert or remove itself runs in the execute state through
// parallel compares and a one-slot shift across all sixteen slots.
`default_nettype none

module sorted_priority_queue_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        req_type_i,
  input  wire logic [spq_pkg::PRIO_W-1:0]  entry_priority_i,
  input  wire logic [spq_pkg::WORD_W-1:0]  entry_payload_i,
  output logic                             done_o,
  output logic [spq_pkg::STAT_W-1:0]       status_o,
  output logic [spq_pkg::PRIO_W-1:0]       head_priority_o,
  output logic [spq_pkg::WORD_W-1:0]       head_payload_o,
  output logic [spq_pkg::FILL_W-1:0]       fill_level_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);
  import spq_pkg::*;

  dp_cmd_t cmd;

  // Sequencing controller.
  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  // Slot storage and result datapath.
  spq_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .req_type_i       (req_type_i),
    .entry_priority_i (entry_priority_i),
    .entry_payload_i  (entry_payload_i),
    .status_o         (status_o),
    .head_priority_o  (head_priority_o),
    .head_payload_o   (head_payload_o),
    .fill_level_o     (fill_level_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/spq_result_checker.sv =====
// Result checker for the sorted priority queue: predicts each request and checks every result.
`timescale 1ns / 100ps

module spq_result_checker
  import spq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic                req_type_i,
  input  logic [PRIO_W-1:0]   entry_priority_i,
  input  logic [WORD_W-1:0]   entry_payload_i,
  input  logic                done_i,
  input  logic [STAT_W-1:0]   status_i,
  input  logic [PRIO_W-1:0]   head_priority_i,
  input  logic [WORD_W-1:0]   head_payload_i,
  input  logic [FILL_W-1:0]   fill_level_i,
  input  logic                is_empty_i,
  input  logic                is_full_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  // One predicted result beat.
  typedef struct {
    status_e             status;
    logic [PRIO_W-1:0]   head_lvl;
    logic [WORD_W-1:0]   head_word;
    logic [FILL_W-1:0]   fill;
    logic                is_empty;
    logic                is_full;
  } queue_result_t;

  // Shadow copy of the queue contents, kept sorted by level.
  logic [PRIO_W-1:0]        lvl_slot [DEPTH];
  logic [PAYLOAD_BITS-1:0]  word_slot[DEPTH];
  int unsigned              held;

  queue_result_t due_results[$];

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    held         = 0;
  end

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic queue_result_t serve_request(req_e kind, logic [PRIO_W-1:0] lvl,
                                                  logic [WORD_W-1:0] word);
    queue_result_t r;
    int unsigned   pos;
    r.status    = STAT_OK;
    r.head_lvl  = '0;
    r.head_word = '0;
    if (kind == REQ_ENQ) begin
      if (held >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        // The new entry goes in front of the first entry of equal or lower urgency.
        pos = held;
        for (int i = int'(held) - 1; i >= 0; i--) begin
          if (lvl <= lvl_slot[i]) pos = i;
        end
        for (int i = int'(held); i > int'(pos); i--) begin
          lvl_slot[i]  = lvl_slot[i-1];
          word_slot[i] = word_slot[i-1];
        end
        lvl_slot[pos]  = lvl;
        word_slot[pos] = PAYLOAD_BITS'(word);
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.head_lvl  = lvl_slot[0];
        r.head_word = WORD_W'(word_slot[0]);
        for (int i = 0; i + 1 < int'(held); i++) begin
          lvl_slot[i]  = lvl_slot[i+1];
          word_slot[i] = word_slot[i+1];
        end
        held--;
      end
    end
    r.fill     = FILL_W'(held);
    r.is_empty = (held == 0);
    r.is_full  = (held >= DEPTH);
    return r;
  endfunction

  task automatic compare_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  // Check the result beat first, then record the request beat taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      held = 0;
      due_results.delete();
    end else begin
      if (done_i === 1'b1) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with no request waiting, expected none, actual status %0h",
                   $time, status_i);
          mismatches_o++;
        end else begin
          want = due_results.pop_front();
          compare_field("status", WORD_W'(want.status), WORD_W'(status_i));
          compare_field("head_priority", WORD_W'(want.head_lvl), WORD_W'(head_priority_i));
          compare_field("head_payload", want.head_word, head_payload_i);
          compare_field("fill_level", WORD_W'(want.fill), WORD_W'(fill_level_i));
          compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(is_empty_i));
          compare_field("is_full", WORD_W'(want.is_full), WORD_W'(is_full_i));
        end
      end
      if (start_i && !busy_i) begin
        due_results.push_back(serve_request(req_e'(req_type_i), entry_priority_i,
                                            entry_payload_i));
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ===== tb/sv/tb_sorted_priority_queue_top.sv =====
// Testbench top for the sorted priority queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int unsigned RANDOM_REQS = 950;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_LEN   = 48;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type_i = REQ_ENQ;
  logic [PRIO_W-1:0]  entry_priority_i = '0;
  logic [WORD_W-1:0]  entry_payload_i = '0;
  logic               done_o;
  logic [STAT_W-1:0]  status_o;
  logic [PRIO_W-1:0]  head_priority_o;
  logic [WORD_W-1:0]  head_payload_o;
  logic [FILL_W-1:0]  fill_level_o;
  logic               is_empty_o;
  logic               is_full_o;

  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  logic               took_beat = 1'b0;

  always #6 clk_i = ~clk_i;

  sorted_priority_queue_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .entry_priority_i (entry_priority_i),
    .entry_payload_i  (entry_payload_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .head_priority_o  (head_priority_o),
    .head_payload_o   (head_payload_o),
    .fill_level_o     (fill_level_o),
    .is_empty_o       (is_empty_o),
    .is_full_o        (is_full_o)
  );

  spq_result_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_type_i       (req_type_i),
    .entry_priority_i (entry_priority_i),
    .entry_payload_i  (entry_payload_i),
    .done_i           (done_o),
    .status_i         (status_o),
    .head_priority_i  (head_priority_o),
    .head_payload_i   (head_payload_o),
    .fill_level_i     (fill_level_o),
    .is_empty_i       (is_empty_o),
    .is_full_i        (is_full_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  // Remember whether the request beat on the ports was taken at the last edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      took_beat <= 1'b0;
    end else begin
      took_beat <= start && !busy;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request beat from a falling edge and hold it until it is taken.
  task automatic issue_request(req_e kind, logic [PRIO_W-1:0] lvl, logic [WORD_W-1:0] word);
    start            <= 1'b1;
    req_type_i       <= kind;
    entry_priority_i <= lvl;
    entry_payload_i  <= word;
    do @(negedge clk_i); while (!took_beat);
  endtask

  // Leave start low for a while, with junk on the request fields.
  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      start            <= 1'b0;
      req_type_i       <= 1'($urandom_range(1));
      entry_priority_i <= PRIO_W'($urandom_range(7));
      entry_payload_i  <= $urandom;
      @(negedge clk_i);
    end
  endtask

  // Random request; levels mostly legal, sometimes 0, 6 or 7.
  task automatic issue_random(int unsigned enq_pct);
    req_e               kind;
    logic [PRIO_W-1:0]  lvl;
    logic [WORD_W-1:0]  word;
    kind = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
    lvl  = ($urandom_range(9) == 0) ? PRIO_W'($urandom_range(7)) : PRIO_W'($urandom_range(1, 5));
    case ($urandom_range(15))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    issue_request(kind, lvl, word);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned enq_pct;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty dequeue, mixed and equal levels up to full, overflow, partial drain.
    issue_request(REQ_DEQ, 3'd2, 32'h1234_5678);
    issue_request(REQ_ENQ, 3'd3, 32'hFFFF_FFFF);
    issue_request(REQ_ENQ, 3'd3, 32'h0000_0000);
    idle_sender(2);
    issue_request(REQ_ENQ, 3'd5, 32'hA5A5_A5A5);
    issue_request(REQ_ENQ, 3'd1, 32'h5A5A_5A5A);
    issue_request(REQ_ENQ, 3'd0, 32'h0000_0001);
    issue_request(REQ_ENQ, 3'd7, 32'h8000_0000);
    idle_sender(1);
    issue_request(REQ_ENQ, 3'd6, 32'h7FFF_FFFF);
    issue_request(REQ_ENQ, 3'd5, 32'hDEAD_BEEF);
    issue_request(REQ_ENQ, 3'd2, 32'h0F0F_0F0F);
    issue_request(REQ_ENQ, 3'd4, 32'hF0F0_F0F0);
    idle_sender(3);
    issue_request(REQ_ENQ, 3'd1, 32'h1111_1111);
    issue_request(REQ_ENQ, 3'd3, 32'h3333_3333);
    issue_request(REQ_ENQ, 3'd5, 32'h5555_5555);
    issue_request(REQ_ENQ, 3'd2, 32'h2222_2222);
    issue_request(REQ_ENQ, 3'd4, 32'h4444_4444);
    issue_request(REQ_ENQ, 3'd1, 32'hCAFE_F00D);
    // The queue is full now, so this one is dropped.
    issue_request(REQ_ENQ, 3'd2, 32'hBAD0_BAD0);
    repeat (6) issue_request(REQ_DEQ, 3'd0, 32'h0);

    // Random part in bursts; the enqueue share cycles so the queue swings between full and empty.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < RANDOM_REQS) begin
        case ((sent / PHASE_LEN) % 4)
          0:       enq_pct = 85;
          2:       enq_pct = 15;
          default: enq_pct = 50;
        endcase
        issue_random(enq_pct);
        sent++;
        burst--;
      end
      if ($urandom_range(3) != 0) idle_sender($urandom_range(1, 8));
    end
    start <= 1'b0;

    // Drain, then watch a little longer for stray result beats.
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_ctrl.sv
hw/rtl/spq_datapath.sv
hw/rtl/sorted_priority_queue_top.sv
tb/sv/spq_result_checker.sv
tb/sv/tb_sorted_priority_queue_top.sv
